// ===== rtl/disk_head_request_scheduler_top_macros.svh =====
// assertion macros, clocked on clk_i, off while rst_ni is low
`ifndef DISK_HEAD_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define DISK_HEAD_REQUEST_SCHEDULER_TOP_MACROS_SVH

`define DHRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhrs check failed");

`define DHRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhrs check failed");

`endif

// ===== rtl/dhrs_pkg.sv =====
`default_nettype none
package dhrs_pkg;

  localparam int TRK_W       = 10;
  localparam int TOT_W       = 16;
  localparam int MAX_REQ_DEF = 32;
  localparam logic [TRK_W-1:0] TRK_MAX = 10'd1023;
  localparam logic [TOT_W-1:0] TOT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {POL_FCFS, POL_SSTF, POL_SCAN, POL_CSCAN} policy_e;
  typedef enum logic [1:0] {CFG_POLICY, CFG_START, CFG_SWEEP_UP, CFG_MAX_TRK} cfg_e;
  typedef enum logic [1:0] {MODE_FIFO, MODE_MIN, MODE_MAX, MODE_NEAR} mode_e;
  typedef enum logic [1:0] {RNG_ALL, RNG_UP, RNG_DN} rng_e;
  typedef enum logic [1:0] {OP_DRAIN, OP_EDGE, OP_END} kind_e;

  typedef struct packed {
    mode_e            mode;
    rng_e             rng;
    logic [TRK_W-1:0] head;
    logic [TRK_W-1:0] h0;
  } ctl_t;

  typedef struct packed {
    logic             found;
    logic [TRK_W-1:0] key;
    logic [TRK_W-1:0] trk;
  } cand_t;

  typedef struct packed {
    kind_e kind;
    mode_e mode;
    rng_e  rng;
    logic  edge_hi;
  } op_t;

  function automatic op_t step_op(policy_e pol, logic up, logic [2:0] step);
    op_t o;
    o = '{kind: OP_END, mode: MODE_FIFO, rng: RNG_ALL, edge_hi: 1'b0};
    unique case (pol)
      POL_FCFS: begin
        if (step == 3'd0) o.kind = OP_DRAIN;
      end
      POL_SSTF: begin
        if (step == 3'd0) begin
          o.kind = OP_DRAIN;
          o.mode = MODE_NEAR;
        end
      end
      POL_SCAN: begin
        if (step == 3'd0 || step == 3'd2) begin
          o.kind = OP_DRAIN;
          if (up == (step == 3'd0)) begin
            o.mode = MODE_MIN;
            o.rng  = RNG_UP;
          end else begin
            o.mode = MODE_MAX;
            o.rng  = RNG_DN;
          end
        end else if (step == 3'd1) begin
          o.kind    = OP_EDGE;
          o.edge_hi = up;
        end
      end
      POL_CSCAN: begin
        if (step == 3'd0 || step == 3'd3) begin
          o.kind = OP_DRAIN;
          o.mode = MODE_MIN;
          o.rng  = (step == 3'd0) ? RNG_UP : RNG_DN;
        end else if (step == 3'd1 || step == 3'd2) begin
          o.kind    = OP_EDGE;
          o.edge_hi = (step == 3'd1);
        end
      end
      default: o.kind = OP_END;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dhrs_cell.sv =====
`default_nettype none
// one request slot; folds its entry into the candidate wave passing by
module dhrs_cell #(
  parameter int IdxW = 5,
  parameter int Idx  = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      ld_en_i,
  input  wire logic [dhrs_pkg::TRK_W-1:0] ld_trk_i,
  input  wire logic                      clr_i,
  input  wire logic                      mark_en_i,
  input  wire logic [IdxW-1:0]           mark_idx_i,
  input  wire dhrs_pkg::ctl_t            ctl_i,
  input  wire logic                      wave_v_i,
  input  wire dhrs_pkg::cand_t           cand_i,
  input  wire logic [IdxW-1:0]           cand_idx_i,
  output logic                           wave_v_o,
  output dhrs_pkg::cand_t                cand_o,
  output logic [IdxW-1:0]                cand_idx_o
);

  logic                       occ_q, served_q;
  logic [dhrs_pkg::TRK_W-1:0] trk_q;
  logic [dhrs_pkg::TRK_W-1:0] key;
  logic                       in_rng, take;

  always_comb begin
    case (ctl_i.rng)
      dhrs_pkg::RNG_UP: in_rng = (trk_q >= ctl_i.h0);
      dhrs_pkg::RNG_DN: in_rng = (trk_q < ctl_i.h0);
      default:          in_rng = 1'b1;
    endcase
    case (ctl_i.mode)
      dhrs_pkg::MODE_MIN:  key = trk_q;
      dhrs_pkg::MODE_MAX:  key = dhrs_pkg::TRK_MAX - trk_q;
      dhrs_pkg::MODE_NEAR: key = (trk_q > ctl_i.head) ? trk_q - ctl_i.head
                                                        : ctl_i.head - trk_q;
      default:             key = '0;
    endcase
    take = occ_q && !served_q && in_rng && (!cand_i.found || key < cand_i.key);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= 1'b0;
      served_q <= 1'b0;
      wave_v_o <= 1'b0;
    end else begin
      wave_v_o <= wave_v_i;
      if (clr_i) begin
        occ_q    <= 1'b0;
        served_q <= 1'b0;
      end else if (ld_en_i) begin
        occ_q    <= 1'b1;
        served_q <= 1'b0;
      end else if (mark_en_i && mark_idx_i == IdxW'(Idx)) begin
        served_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_en_i) trk_q <= ld_trk_i;
    if (take) begin
      cand_o     <= '{found: 1'b1, key: key, trk: trk_q};
      cand_idx_o <= IdxW'(Idx);
    end else begin
      cand_o     <= cand_i;
      cand_idx_o <= cand_idx_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/disk_head_request_scheduler_top.sv =====
// Disk head request scheduler.
// Input channel (in_valid_i/in_ready_o): one track request per word, last_i
// closes the batch. Requests beyond MaxRequests are dropped; tracks above
// max_track are clamped. in_ready_o is high only while the block is idle.
// After the last word the block emits the service order for the configured
// policy on the output channel (out_valid_o/out_ready_i), one word per step,
// final_res_o set on the last word of the batch.
// Each selection runs a candidate wave through the chain of MaxRequests
// cells, one cell per cycle, then the result is registered and evaluated;
// a sweep edge is produced in the step state; an empty selection ends a sweep part.
// Results go through a one-word lookahead and an output register, so the
// block keeps working while a finished word waits; it stalls only when both
// are full and the receiver holds out_ready_i low.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once
// and are meant for idle periods. Reset: policy FCFS, start track 0, sweep
// up, max track 1023, no stored requests, output empty.
`default_nettype none
module disk_head_request_scheduler_top #(
  parameter int MaxRequests = dhrs_pkg::MAX_REQ_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [dhrs_pkg::TRK_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [dhrs_pkg::TRK_W-1:0] track_i,
  input  wire logic                       last_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [dhrs_pkg::TRK_W-1:0]      served_track_o,
  output logic [dhrs_pkg::TRK_W-1:0]      step_distance_o,
  output logic [dhrs_pkg::TOT_W-1:0]      total_movement_o,
  output logic                            edge_visit_o,
  output logic                            final_res_o
);

  localparam int IdxW = $clog2(MaxRequests);
  localparam int CntW = $clog2(MaxRequests + 1);
  localparam int TW   = dhrs_pkg::TRK_W;
  localparam int OW   = dhrs_pkg::TOT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  dhrs_pkg::policy_e policy_q;
  logic [TW-1:0]     start_q, max_trk_q;
  logic              sweep_up_q;

  logic [2:0]        state_q, step_q;
  logic [CntW-1:0]   count_q;
  logic [TW-1:0]     head_q, h0_q;
  logic [OW-1:0]     total_q;
  dhrs_pkg::op_t     op;
  dhrs_pkg::ctl_t    ctl;

  logic              pend_v_q, pend_edge_q;
  logic [TW-1:0]     pend_trk_q, pend_dist_q;
  logic [OW-1:0]     pend_tot_q;

  dhrs_pkg::cand_t   res_q;
  logic [IdxW-1:0]   res_idx_q;

  logic              wave_v [MaxRequests+1];
  dhrs_pkg::cand_t   cand   [MaxRequests+1];
  logic [IdxW-1:0]   cidx   [MaxRequests+1];

  logic              accept, load, inject, mark, clr, out_free;
  logic [TW-1:0]     trk_clamp, start_clamp;
  logic [TW-1:0]     prod_trk, prod_dist;
  logic [OW:0]       prod_sum;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = accept && (count_q < CntW'(MaxRequests));
  assign trk_clamp   = (track_i > max_trk_q) ? max_trk_q : track_i;
  assign start_clamp = (start_q > max_trk_q) ? max_trk_q : start_q;
  assign out_free    = !out_valid_o || out_ready_i;
  assign op          = dhrs_pkg::step_op(policy_q, sweep_up_q, step_q);
  assign ctl         = '{mode: op.mode, rng: op.rng, head: head_q, h0: h0_q};
  assign inject      = (state_q == ST_STEP) && (op.kind == dhrs_pkg::OP_DRAIN);
  assign mark        = (state_q == ST_EVAL) && res_q.found && (!pend_v_q || out_free);
  assign clr         = (state_q == ST_DONE) && (!pend_v_q || out_free);

  assign wave_v[0] = inject;
  assign cand[0]   = '{found: 1'b0, key: '0, trk: '0};
  assign cidx[0]   = '0;

  for (genvar g = 0; g < MaxRequests; g++) begin : g_cell
    dhrs_cell #(.IdxW(IdxW), .Idx(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ld_en_i    (load && count_q[IdxW-1:0] == IdxW'(g)),
      .ld_trk_i   (trk_clamp),
      .clr_i      (clr),
      .mark_en_i  (mark),
      .mark_idx_i (res_idx_q),
      .ctl_i      (ctl),
      .wave_v_i   (wave_v[g]),
      .cand_i     (cand[g]),
      .cand_idx_i (cidx[g]),
      .wave_v_o   (wave_v[g+1]),
      .cand_o     (cand[g+1]),
      .cand_idx_o (cidx[g+1])
    );
  end

  always_comb begin
    prod_trk  = (state_q == ST_EVAL) ? res_q.trk : (op.edge_hi ? max_trk_q : '0);
    prod_dist = (prod_trk > head_q) ? prod_trk - head_q : head_q - prod_trk;
    prod_sum  = {1'b0, total_q} + (OW+1)'(prod_dist);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= dhrs_pkg::POL_FCFS;
      start_q     <= '0;
      sweep_up_q  <= 1'b1;
      max_trk_q   <= dhrs_pkg::TRK_MAX;
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      total_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (dhrs_pkg::cfg_e'(cfg_idx_i))
          dhrs_pkg::CFG_POLICY:   policy_q   <= dhrs_pkg::policy_e'(cfg_wdata_i[1:0]);
          dhrs_pkg::CFG_START:    start_q    <= cfg_wdata_i;
          dhrs_pkg::CFG_SWEEP_UP: sweep_up_q <= cfg_wdata_i[0];
          dhrs_pkg::CFG_MAX_TRK:  max_trk_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_ready_i) out_valid_o <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (load) count_q <= count_q + 1'b1;
          if (accept && last_i) begin
            h0_q     <= start_clamp;
            head_q   <= start_clamp;
            total_q  <= '0;
            step_q   <= '0;
            pend_v_q <= 1'b0;
            state_q  <= ST_STEP;
          end
        end
        ST_STEP: begin
          unique case (op.kind)
            dhrs_pkg::OP_DRAIN: state_q <= ST_PASS;
            dhrs_pkg::OP_EDGE: begin
              if (!pend_v_q || out_free) begin
                step_q <= step_q + 1'b1;
              end
            end
            default: state_q <= ST_DONE;
          endcase
        end
        ST_PASS: begin
          if (wave_v[MaxRequests]) begin
            res_q     <= cand[MaxRequests];
            res_idx_q <= cidx[MaxRequests];
            state_q   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!res_q.found) begin
            step_q  <= step_q + 1'b1;
            state_q <= ST_STEP;
          end else if (!pend_v_q || out_free) begin
            state_q <= ST_STEP;
          end
        end
        ST_DONE: begin
          if (clr) begin
            count_q  <= '0;
            pend_v_q <= 1'b0;
            state_q  <= ST_IDLE;
            if (pend_v_q) begin
              out_valid_o      <= 1'b1;
              served_track_o   <= pend_trk_q;
              step_distance_o  <= pend_dist_q;
              total_movement_o <= pend_tot_q;
              edge_visit_o     <= pend_edge_q;
              final_res_o      <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // produce a word into the lookahead, pushing the older one out
      if (mark || ((state_q == ST_STEP) && (op.kind == dhrs_pkg::OP_EDGE) &&
                   (!pend_v_q || out_free))) begin
        if (pend_v_q) begin
          out_valid_o      <= 1'b1;
          served_track_o   <= pend_trk_q;
          step_distance_o  <= pend_dist_q;
          total_movement_o <= pend_tot_q;
          edge_visit_o     <= pend_edge_q;
          final_res_o      <= 1'b0;
        end
        pend_v_q    <= 1'b1;
        pend_trk_q  <= prod_trk;
        pend_dist_q <= prod_dist;
        pend_tot_q  <= prod_sum[OW] ? dhrs_pkg::TOT_MAX : prod_sum[OW-1:0];
        pend_edge_q <= !mark;
        head_q      <= prod_trk;
        total_q     <= prod_sum[OW] ? dhrs_pkg::TOT_MAX : prod_sum[OW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dhrs_checker.sv =====
`default_nettype none
`include "disk_head_request_scheduler_top_macros.svh"
module dhrs_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       last_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [dhrs_pkg::TRK_W-1:0] served_track_o,
  input wire logic [dhrs_pkg::TRK_W-1:0] step_distance_o,
  input wire logic [dhrs_pkg::TOT_W-1:0] total_movement_o
);

  // stalled word holds
  `DHRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(served_track_o))
  // running total never below the current step
  `DHRS_ASSERT_NOW(a_total_ge_step, out_valid_o, dhrs_pkg::TOT_W'(step_distance_o) <= total_movement_o)
  // a word that does not close the batch yields no result
  `DHRS_ASSERT_NEXT(a_no_early_out, in_valid_i && in_ready_o && !last_i && !out_valid_o, !out_valid_o)
  // closing the batch makes the block busy
  `DHRS_ASSERT_NEXT(a_busy_after_last, in_valid_i && in_ready_o && last_i, !in_ready_o)

endmodule

bind disk_head_request_scheduler_top dhrs_checker u_dhrs_checker (.*);
`default_nettype wire

// ===== dv/disk_head_request_scheduler_checker.sv =====
`default_nettype none
module disk_head_request_scheduler_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [dhrs_pkg::TRK_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic [dhrs_pkg::TRK_W-1:0] track_i,
  input  wire logic                       last_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [dhrs_pkg::TRK_W-1:0] served_track_i,
  input  wire logic [dhrs_pkg::TRK_W-1:0] step_distance_i,
  input  wire logic [dhrs_pkg::TOT_W-1:0] total_movement_i,
  input  wire logic                       edge_visit_i,
  input  wire logic                       final_res_i,
  output int                              fail_cnt_o,
  output int                              pending_o,
  output int                              served_cnt_o,
  output int                              batch_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = dhrs_pkg::MAX_REQ_DEF;
  localparam int TW    = dhrs_pkg::TRK_W;
  localparam int OW    = dhrs_pkg::TOT_W;

  typedef struct packed {
    logic [TW-1:0] trk;
    logic [TW-1:0] dst;
    logic [OW-1:0] tot;
    logic          edge_v;
    logic          fin;
  } visit_t;

  dhrs_pkg::policy_e pol;
  logic [TW-1:0]     start_trk;
  logic              up;
  logic [TW-1:0]     max_trk;

  logic [TW-1:0] req_trk [Depth];
  logic          done [Depth];
  int            req_cnt;
  int            head;
  int            total;
  visit_t        visit_q[$];

  function automatic int pick_slot(dhrs_pkg::mode_e m, int lo, int hi);
    int best;
    int bkey;
    int key;
    int tv;
    best = -1;
    bkey = 0;
    for (int i = 0; i < req_cnt; i++) begin
      tv = int'(req_trk[i]);
      if (!done[i] && tv >= lo && tv < hi) begin
        if (m == dhrs_pkg::MODE_MIN) key = tv;
        else if (m == dhrs_pkg::MODE_MAX) key = 1023 - tv;
        else key = (tv > head) ? tv - head : head - tv;
        if (best < 0 || key < bkey) begin
          best = i;
          bkey = key;
        end
      end
    end
    return best;
  endfunction

  task automatic visit(int t, logic e);
    visit_t v;
    int d;
    d = (t > head) ? t - head : head - t;
    total = total + d;
    if (total > 65535) total = 65535;
    head = t;
    v.trk = TW'(t);
    v.dst = TW'(d);
    v.tot = OW'(total);
    v.edge_v = e;
    v.fin = 1'b0;
    visit_q.push_back(v);
  endtask

  task automatic sweep(dhrs_pkg::mode_e m, int lo, int hi);
    int k;
    k = pick_slot(m, lo, hi);
    while (k >= 0) begin
      done[k] = 1'b1;
      visit(int'(req_trk[k]), 1'b0);
      k = pick_slot(m, lo, hi);
    end
  endtask

  task automatic plan_batch();
    int h0;
    int first;
    h0 = (start_trk > max_trk) ? int'(max_trk) : int'(start_trk);
    head = h0;
    total = 0;
    first = visit_q.size();
    case (pol)
      dhrs_pkg::POL_FCFS: for (int i = 0; i < req_cnt; i++) visit(int'(req_trk[i]), 1'b0);
      dhrs_pkg::POL_SSTF: sweep(dhrs_pkg::MODE_NEAR, 0, 1024);
      dhrs_pkg::POL_SCAN: begin
        if (up) begin
          sweep(dhrs_pkg::MODE_MIN, h0, 1024);
          visit(int'(max_trk), 1'b1);
          sweep(dhrs_pkg::MODE_MAX, 0, h0);
        end else begin
          sweep(dhrs_pkg::MODE_MAX, 0, h0);
          visit(0, 1'b1);
          sweep(dhrs_pkg::MODE_MIN, h0, 1024);
        end
      end
      default: begin
        sweep(dhrs_pkg::MODE_MIN, h0, 1024);
        visit(int'(max_trk), 1'b1);
        visit(0, 1'b1);
        sweep(dhrs_pkg::MODE_MIN, 0, h0);
      end
    endcase
    if (visit_q.size() > first) visit_q[visit_q.size()-1].fin = 1'b1;
    req_cnt = 0;
    for (int i = 0; i < Depth; i++) done[i] = 1'b0;
    batch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    visit_t got;
    visit_t want;
    logic [TW-1:0] t;
    if (!rst_ni) begin
      pol = dhrs_pkg::POL_FCFS;
      start_trk = '0;
      up = 1'b1;
      max_trk = dhrs_pkg::TRK_MAX;
      req_cnt = 0;
      for (int i = 0; i < Depth; i++) done[i] = 1'b0;
      visit_q.delete();
      fail_cnt_o = 0;
      served_cnt_o = 0;
      batch_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (dhrs_pkg::cfg_e'(cfg_idx_i))
          dhrs_pkg::CFG_POLICY:   pol = dhrs_pkg::policy_e'(cfg_wdata_i[1:0]);
          dhrs_pkg::CFG_START:    start_trk = cfg_wdata_i;
          dhrs_pkg::CFG_SWEEP_UP: up = cfg_wdata_i[0];
          default:                max_trk = cfg_wdata_i;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        t = (track_i > max_trk) ? max_trk : track_i;
        if (req_cnt < Depth) begin
          req_trk[req_cnt] = t;
          done[req_cnt] = 1'b0;
          req_cnt++;
        end
        if (last_i) plan_batch();
      end
      if (out_valid_i && out_ready_i) begin
        got = '{served_track_i, step_distance_i, total_movement_i, edge_visit_i, final_res_i};
        served_cnt_o++;
        if (visit_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) $display("unexpected word: trk %0d dist %0d tot %0d", got.trk,
                                         got.dst, got.tot);
        end else begin
          want = visit_q.pop_front();
          if (got !== want) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display({"mismatch: exp trk %0d dist %0d tot %0d edge %0b fin %0b,",
                        " got trk %0d dist %0d tot %0d edge %0b fin %0b"},
                       want.trk, want.dst, want.tot, want.edge_v, want.fin,
                       got.trk, got.dst, got.tot, got.edge_v, got.fin);
          end
        end
      end
    end
    pending_o = visit_q.size();
  end
endmodule
`default_nettype wire

// ===== dv/tb_disk_head_request_scheduler_top.sv =====
`default_nettype none
module tb_disk_head_request_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam int TW = dhrs_pkg::TRK_W;
  localparam int OW = dhrs_pkg::TOT_W;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_idx = '0;
  logic [TW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [TW-1:0] track = '0;
  logic          last = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [TW-1:0] served_track;
  logic [TW-1:0] step_distance;
  logic [OW-1:0] total_movement;
  logic          edge_visit;
  logic          final_res;

  int fail_cnt;
  int pending;
  int served_cnt;
  int batch_cnt;
  int item_cnt = 0;
  int quiet = 0;
  bit calm = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  disk_head_request_scheduler_top u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .track_i(track), .last_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .served_track_o(served_track), .step_distance_o(step_distance),
    .total_movement_o(total_movement), .edge_visit_o(edge_visit), .final_res_o(final_res)
  );

  disk_head_request_scheduler_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .track_i(track), .last_i(last),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .served_track_i(served_track), .step_distance_i(step_distance),
    .total_movement_i(total_movement), .edge_visit_i(edge_visit), .final_res_i(final_res),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .served_cnt_o(served_cnt),
    .batch_cnt_o(batch_cnt)
  );

  always @(negedge clk_i)
    out_ready <= calm || ($urandom_range(99) >= 14);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
        $display("watchdog: no traffic for %0d cycles", StallLimit);
        $display("disk_head_request_scheduler_top verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(logic [TW-1:0] t, logic l);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    track = t;
    last = l;
    #1;
    while (!in_ready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    item_cnt++;
  endtask

  task automatic send_batch(int n, int kind);
    logic [TW-1:0] t;
    logic [TW-1:0] prev;
    prev = TW'($urandom_range(1023));
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: t = TW'($urandom_range(1023));
        1: t = (i % 3 == 2) ? prev : TW'($urandom_range(1023));
        2: t = ($urandom_range(3) == 0) ? 10'd1023 : TW'($urandom_range(1023, 900));
        default: t = TW'($urandom_range(40));
      endcase
      prev = t;
      send_word(t, i == n - 1);
    end
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(dhrs_pkg::cfg_e idx, logic [TW-1:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic setup(dhrs_pkg::policy_e p, logic [TW-1:0] s, logic u, logic [TW-1:0] m);
    settle();
    write_reg(dhrs_pkg::CFG_POLICY, TW'(p));
    write_reg(dhrs_pkg::CFG_START, s);
    write_reg(dhrs_pkg::CFG_SWEEP_UP, TW'(u));
    write_reg(dhrs_pkg::CFG_MAX_TRK, m);
  endtask

  initial begin
    dhrs_pkg::policy_e p;
    logic [TW-1:0] m;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // single-word batches on reset defaults, tie and clamp batches per policy, one overfull batch
    send_word(10'd0, 1'b1);
    send_word(10'd1023, 1'b1);
    for (int k = 0; k < 4; k++) begin
      p = dhrs_pkg::policy_e'(k[1:0]);
      setup(p, 10'd500, k[0], 10'd1023);
      send_word(10'd500, 1'b0);
      send_word(10'd400, 1'b0);
      send_word(10'd600, 1'b0);
      send_word(10'd400, 1'b1);
      setup(p, 10'd1023, 1'b0, 10'd600);
      send_word(10'd1023, 1'b0);
      send_word(10'd0, 1'b1);
    end
    setup(dhrs_pkg::POL_SCAN, 10'd0, 1'b1, 10'd1);
    send_word(10'd5, 1'b0);
    send_word(10'd0, 1'b1);
    setup(dhrs_pkg::POL_SSTF, 10'd512, 1'b1, 10'd1023);
    send_batch(34, 0);

    while (item_cnt < 470) begin
      settle();
      p = dhrs_pkg::policy_e'(2'($urandom_range(3)));
      case ($urandom_range(3))
        0: m = 10'd1023;
        1: m = TW'($urandom_range(1, 8));
        default: m = TW'($urandom_range(1023, 1));
      endcase
      setup(p, ($urandom_range(4) == 0) ? 10'd1023 : TW'($urandom_range(1023)),
            1'($urandom_range(1)), m);
      calm = (item_cnt > 200 && item_cnt < 280);
      for (int b = 0; b < 6; b++)
        send_batch(($urandom_range(15) == 0) ? $urandom_range(33, 28) : $urandom_range(8, 1),
                   $urandom_range(3));
    end

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("%0d requests in %0d batches over all four policies, %0d results checked",
             item_cnt, batch_cnt, served_cnt);
    if (fail_cnt == 0) begin
      $display("disk_head_request_scheduler_top verification clean");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("disk_head_request_scheduler_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
